/* sv/bsos_pkg.sv */
// Shared constants and types of the batch sigma outlier statistics unit.
package bsos_pkg;

  localparam int MAX_SAMPLES = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W = ADDR_W + 1;
  localparam int SUM_W = SAMPLE_BITS + ADDR_W + 1;
  localparam int SQS_W = 2 * SAMPLE_BITS + ADDR_W;
  localparam int SPR_W = 47;
  localparam int ROOT_W = 24;
  localparam int THR_W = 55;
  localparam int DEV_W = 26;
  localparam int DSQ_W = 50;
  localparam int NUM_W = 33;
  localparam int DEN_W = 25;
  localparam int OUT_W = 17;
  localparam int K_W = 4;
  localparam int PADDR_W = 3;

  localparam logic [OUT_W-1:0] ONE_Q16 = OUT_W'(65536);
  localparam logic [K_W-1:0] K_RESET = K_W'(2);
  localparam logic [PADDR_W-1:0] ADDR_SIGMAS = PADDR_W'(0);

  typedef struct packed {
    logic start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

endpackage

/* sv/bsos_sample_ram.sv */
// Sample buffer: single-port synchronous memory with registered read data.
module bsos_sample_ram import bsos_pkg::*; (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ADDR_W-1:0]             addr,
  input  logic signed [SAMPLE_BITS-1:0] wdata,
  output logic signed [SAMPLE_BITS-1:0] rdata
);

  logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/bsos_isqrt.sv */
// Iterative integer square root, one result bit per cycle.
module bsos_isqrt import bsos_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SPR_W-1:0]    value,
  output logic                done,
  output logic [ROOT_W-1:0]   root
);

  localparam int W = 2 * ROOT_W;

  logic [W-1:0] v_r, v_nxt;
  logic [W-1:0] root_r, root_nxt;
  logic [W-1:0] bit_r, bit_nxt;
  logic         busy_r, done_r;
  logic [W-1:0] trial;

  always_comb begin
    trial    = root_r + bit_r;
    v_nxt    = v_r;
    root_nxt = root_r >> 1;
    bit_nxt  = bit_r >> 2;
    if (v_r >= trial) begin
      v_nxt    = v_r - trial;
      root_nxt = (root_r >> 1) + bit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && bit_r[0]) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= W'(value);
      root_r <= '0;
      bit_r  <= W'(1) << (W - 2);
    end else if (busy_r) begin
      v_r    <= v_nxt;
      root_r <= root_nxt;
      bit_r  <= bit_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r[ROOT_W-1:0];

endmodule

/* sv/bsos_div.sv */
// Restoring divider, one quotient bit per cycle.
module bsos_div import bsos_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   sh;
  logic             ge;

  assign sh = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
  assign ge = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(NUM_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - CW'(1);
      done_r <= (cnt_r == CW'(1));
      busy_r <= (cnt_r != CW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= ge ? (sh - {1'b0, den_r}) : sh;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* sv/batch_sigma_outlier_stats_unit.sv */
// Top level: batch loader, statistics sequencer and outlier scan.
//
// Channel | Direction | Handshake        | Word
// in_     | input     | in_valid/ready   | sample, last
// out_    | output    | out_valid/ready  | score, confidence, fraction, count, size, flag
// cfg_    | input     | APB write/read   | outlier_sigmas at byte address 0
//
// A sample is taken whenever in_valid is high while the block is loading.
// A closing sample then holds the block through the setup states NQ_LO, NQ_HI, SPREAD,
// THR_LO and THR_HI, a scan of the sample memory overlapping the square root, and two
// divisions.
// Reset is synchronous and clears the batch state; the sample memory is not cleared.
// Samples keep loading while a result waits on out_ready; the next close waits for it.
module batch_sigma_outlier_stats_unit import bsos_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [OUT_W-1:0]              out_score,
  output logic [OUT_W-1:0]              out_confidence,
  output logic [OUT_W-1:0]              out_outlier_fraction,
  output logic [CNT_W-1:0]              out_outlier_count,
  output logic [CNT_W-1:0]              out_batch_size,
  output logic                          out_overflowed,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [PADDR_W-1:0]            cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_NQ_LO  = 4'd1;
  localparam logic [3:0] S_NQ_HI  = 4'd2;
  localparam logic [3:0] S_SPREAD = 4'd3;
  localparam logic [3:0] S_THR_LO = 4'd4;
  localparam logic [3:0] S_THR_HI = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_SQW    = 4'd7;
  localparam logic [3:0] S_DIV1   = 4'd8;
  localparam logic [3:0] S_DIV2   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]              state_r, state_nxt;
  logic [K_W-1:0]          k_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQS_W-1:0]        sqs_r;
  logic                    drop_r;

  logic [2*K_W-1:0]        k2_r;
  logic [28:0]             plo_r;
  logic [DSQ_W-1:0]        ssq_r;
  logic [SPR_W-1:0]        nq_r, spr_r;
  logic [31:0]             thr_lo_r;
  logic [THR_W-1:0]        thr_r;

  logic [CNT_W-1:0]        rd_idx_r;
  logic                    p1_v_r, p2_v_r, p3_v_r;
  logic signed [DEV_W-1:0] dev_r;
  logic [DSQ_W-1:0]        dsq_r;
  logic [CNT_W-1:0]        outl_r;
  logic [OUT_W-1:0]        score_r;

  logic                    out_valid_r;
  logic [OUT_W-1:0]        o_score_r, o_conf_r, o_ratio_r;
  logic [CNT_W-1:0]        o_outl_r, o_size_r;
  logic                    o_drop_r;

  logic                    in_acc, store, issue, wr_cfg;
  logic [ADDR_W-1:0]       ram_addr;
  logic signed [SAMPLE_BITS-1:0] ram_rdata;
  logic [SAMPLE_BITS-1:0]  x_mag;
  logic [SUM_W-1:0]        s_mag;
  logic signed [DEV_W-1:0] nx;
  logic [DEV_W-1:0]        dev_mag;
  logic                    sq_done;
  logic [ROOT_W-1:0]       sq_root;
  div_req_t                div_req;
  logic                    div_done;
  logic [NUM_W-1:0]        div_quot;
  logic                    out_free;

  assign in_ready = (state_r == S_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign store    = cnt_r < CNT_W'(MAX_SAMPLES);
  assign issue    = (state_r == S_SCAN) && (rd_idx_r < cnt_r);
  assign out_free = !out_valid_r || out_ready;
  assign ram_addr = (state_r == S_SCAN) ? rd_idx_r[ADDR_W-1:0] : cnt_r[ADDR_W-1:0];

  assign x_mag = in_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_sample) : in_sample;
  assign s_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign nx = $signed({1'b0, cnt_r}) * ram_rdata;
  assign dev_mag = dev_r[DEV_W-1] ? DEV_W'(-dev_r) : DEV_W'(dev_r);

  bsos_sample_ram u_ram (
    .clk   (clk),
    .we    (in_acc && store),
    .addr  (ram_addr),
    .wdata (in_sample),
    .rdata (ram_rdata)
  );

  bsos_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_THR_LO),
    .value (spr_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  bsos_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = NUM_W'(cnt_r) << 24;
    div_req.den   = DEN_W'({cnt_r, 8'd0}) + DEN_W'(sq_root);
    if (state_r == S_SQW && sq_done) begin
      div_req.start = 1'b1;
    end else if (state_r == S_DIV1) begin
      div_req.num   = NUM_W'(outl_r) << 16;
      div_req.den   = DEN_W'(cnt_r);
      div_req.start = div_done;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:   if (in_acc && in_last) state_nxt = S_NQ_LO;
      S_NQ_LO:  state_nxt = S_NQ_HI;
      S_NQ_HI:  state_nxt = S_SPREAD;
      S_SPREAD: state_nxt = S_THR_LO;
      S_THR_LO: state_nxt = S_THR_HI;
      S_THR_HI: state_nxt = S_SCAN;
      S_SCAN: begin
        if (!issue && !p1_v_r && !p2_v_r && !p3_v_r) state_nxt = S_SQW;
      end
      S_SQW:    if (sq_done) state_nxt = S_DIV1;
      S_DIV1:   if (div_done) state_nxt = S_DIV2;
      S_DIV2:   if (div_done) state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_LOAD;
      default:  state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign wr_cfg = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= K_RESET;
    end else if (wr_cfg && cfg_paddr == ADDR_SIGMAS) begin
      k_r <= cfg_pwdata[K_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_SIGMAS) ? 32'(k_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sum_r  <= '0;
      sqs_r  <= '0;
      drop_r <= 1'b0;
    end else if (in_acc) begin
      if (store) begin
        cnt_r <= cnt_r + CNT_W'(1);
        sum_r <= sum_r + SUM_W'(in_sample);
        sqs_r <= sqs_r + SQS_W'(x_mag * x_mag);
      end else begin
        drop_r <= 1'b1;
      end
    end else if (state_r == S_DONE && out_free) begin
      cnt_r  <= '0;
      sum_r  <= '0;
      sqs_r  <= '0;
      drop_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_NQ_LO: begin
        plo_r <= cnt_r * sqs_r[19:0];
        ssq_r <= s_mag * s_mag;
        k2_r  <= k_r * k_r;
      end
      S_NQ_HI:  nq_r <= (SPR_W'(cnt_r * sqs_r[SQS_W-1:20]) << 20) + SPR_W'(plo_r);
      S_SPREAD: spr_r <= nq_r - SPR_W'(ssq_r);
      S_THR_LO: thr_lo_r <= k2_r * spr_r[23:0];
      S_THR_HI: thr_r <= (THR_W'(k2_r * spr_r[SPR_W-1:24]) << 24) + THR_W'(thr_lo_r);
      default: ;
    endcase
    dev_r <= nx - DEV_W'(sum_r);
    dsq_r <= dev_mag * dev_mag;
    if (state_r == S_DIV1 && div_done) begin
      score_r <= div_quot[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      p1_v_r   <= 1'b0;
      p2_v_r   <= 1'b0;
      p3_v_r   <= 1'b0;
      outl_r   <= '0;
    end else begin
      p1_v_r <= issue;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      if (state_r == S_THR_HI) begin
        rd_idx_r <= '0;
        outl_r   <= '0;
      end else begin
        if (issue) rd_idx_r <= rd_idx_r + CNT_W'(1);
        if (p3_v_r && THR_W'(dsq_r) > thr_r) outl_r <= outl_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      if (cnt_r == '0) begin
        o_score_r <= ONE_Q16;
        o_ratio_r <= '0;
        o_conf_r  <= ONE_Q16;
      end else begin
        o_score_r <= score_r;
        o_ratio_r <= div_quot[OUT_W-1:0];
        o_conf_r  <= ONE_Q16 - div_quot[OUT_W-1:0];
      end
      o_outl_r <= outl_r;
      o_size_r <= cnt_r;
      o_drop_r <= drop_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_score            = o_score_r;
  assign out_confidence       = o_conf_r;
  assign out_outlier_fraction = o_ratio_r;
  assign out_outlier_count    = o_outl_r;
  assign out_batch_size       = o_size_r;
  assign out_overflowed       = o_drop_r;

endmodule

/* sv/bsos_checker.sv */
// Port-level assertions for the batch sigma outlier statistics unit.
module bsos_checker import bsos_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [OUT_W-1:0]              out_score,
  input logic [OUT_W-1:0]              out_confidence,
  input logic [OUT_W-1:0]              out_outlier_fraction,
  input logic [CNT_W-1:0]              out_outlier_count,
  input logic [CNT_W-1:0]              out_batch_size
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_score) && $stable(out_batch_size))
    else $error("Result word changed while stalled.");

  a_conf_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_confidence + out_outlier_fraction) == ONE_Q16)
    else $error("Confidence and fraction do not sum to one.");

  a_count_le_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_outlier_count <= out_batch_size && out_batch_size != '0)
    else $error("Outlier count exceeds batch size.");

  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_score <= ONE_Q16 && out_outlier_fraction <= ONE_Q16)
    else $error("Score or fraction out of range.");

endmodule

bind batch_sigma_outlier_stats_unit bsos_checker u_bsos_checker (.*);

/* tb/batch_sigma_outlier_stats_checker.sv */
// Checker that predicts and compares the result words of the outlier statistics unit.
`timescale 1ns / 100ps
module batch_sigma_outlier_stats_checker import bsos_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_last,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [OUT_W-1:0]       out_score,
  input  logic [OUT_W-1:0]       out_confidence,
  input  logic [OUT_W-1:0]       out_outlier_fraction,
  input  logic [CNT_W-1:0]       out_outlier_count,
  input  logic [CNT_W-1:0]       out_batch_size,
  input  logic                   out_overflowed,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [PADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output int                     fail_count,
  output int                     pending_stats,
  output int                     batches_seen
);

  typedef struct packed {
    logic [OUT_W-1:0] score;
    logic [OUT_W-1:0] confidence;
    logic [OUT_W-1:0] ratio;
    logic [CNT_W-1:0] outliers;
    logic [CNT_W-1:0] size;
    logic             overflowed;
  } batch_stats_t;

  batch_stats_t    stats_queue[$];
  longint          batch_samples[MAX_SAMPLES];
  int              batch_len;
  longint          batch_sum;
  longint unsigned batch_sqsum;
  logic            batch_dropped;
  logic [K_W-1:0]  sigma_mult;

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic batch_stats_t close_batch();
    batch_stats_t r;
    longint unsigned n, spread, k2, dev, hits, ratio, score;
    longint d;
    n = batch_len;
    spread = n * batch_sqsum - longint'(batch_sum * batch_sum);
    k2 = sigma_mult * sigma_mult;
    hits = 0;
    for (int i = 0; i < batch_len; i++) begin
      d = longint'(n) * batch_samples[i] - batch_sum;
      dev = d < 0 ? -d : d;
      if (dev * dev > k2 * spread) hits++;
    end
    if (n == 0) begin
      score = 65536;
      ratio = 0;
    end else begin
      score = (64'd65536 * 256 * n) / (256 * n + floor_root(spread));
      ratio = (64'd65536 * hits) / n;
    end
    r.score = score[OUT_W-1:0];
    r.confidence = OUT_W'(65536 - ratio);
    r.ratio = ratio[OUT_W-1:0];
    r.outliers = hits[CNT_W-1:0];
    r.size = n[CNT_W-1:0];
    r.overflowed = batch_dropped;
    return r;
  endfunction

  always @(posedge clk) begin
    batch_stats_t e;
    longint x;
    int errs;
    if (!rst_n) begin
      batch_len = 0;
      batch_sum = 0;
      batch_sqsum = 0;
      batch_dropped = 1'b0;
      sigma_mult = K_RESET;
      stats_queue.delete();
      fail_count <= 0;
      batches_seen <= 0;
      pending_stats <= 0;
    end else begin
      errs = 0;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_SIGMAS)
        sigma_mult = cfg_pwdata[K_W-1:0];
      if (out_valid && out_ready) begin
        batches_seen <= batches_seen + 1;
        if (stats_queue.size() == 0) begin
          $error("result word with no batch closed");
          errs++;
        end else begin
          e = stats_queue.pop_front();
          if (e.score !== out_score) begin
            $error("score: expected %0d, got %0d", e.score, out_score);
            errs++;
          end
          if (e.confidence !== out_confidence) begin
            $error("confidence: expected %0d, got %0d", e.confidence, out_confidence);
            errs++;
          end
          if (e.ratio !== out_outlier_fraction) begin
            $error("outlier_fraction: expected %0d, got %0d", e.ratio,
                   out_outlier_fraction);
            errs++;
          end
          if (e.outliers !== out_outlier_count) begin
            $error("outlier_count: expected %0d, got %0d", e.outliers, out_outlier_count);
            errs++;
          end
          if (e.size !== out_batch_size) begin
            $error("batch_size: expected %0d, got %0d", e.size, out_batch_size);
            errs++;
          end
          if (e.overflowed !== out_overflowed) begin
            $error("overflowed: expected %0d, got %0d", e.overflowed, out_overflowed);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        x = longint'($signed(in_sample));
        if (batch_len < MAX_SAMPLES) begin
          batch_samples[batch_len] = x;
          batch_len = batch_len + 1;
          batch_sum = batch_sum + x;
          batch_sqsum = batch_sqsum + longint'(x * x);
        end else begin
          batch_dropped = 1'b1;
        end
        if (in_last) begin
          stats_queue.push_back(close_batch());
          batch_len = 0;
          batch_sum = 0;
          batch_sqsum = 0;
          batch_dropped = 1'b0;
        end
      end
      fail_count <= fail_count + errs;
      pending_stats <= stats_queue.size();
    end
  end

endmodule

/* tb/tb_batch_sigma_outlier_stats_unit.sv */
// Testbench top: stimulus, configuration writes and verdict for the outlier statistics unit.
`timescale 1ns / 100ps
module tb_batch_sigma_outlier_stats_unit;
  import bsos_pkg::*;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic                          in_last = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [OUT_W-1:0]              out_score, out_confidence, out_outlier_fraction;
  logic [CNT_W-1:0]              out_outlier_count, out_batch_size;
  logic                          out_overflowed;
  logic                          cfg_psel = 1'b0;
  logic                          cfg_penable = 1'b0;
  logic                          cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0]            cfg_paddr = '0;
  logic [31:0]                   cfg_pwdata = '0;
  logic [31:0]                   cfg_prdata;
  logic                          cfg_pready;
  int                            fail_count, pending_stats, batches_seen;
  int                            words_sent = 0;
  bit                            calm = 1'b0;
  bit                            hold_off = 1'b0;

  always #4 clk = ~clk;

  batch_sigma_outlier_stats_unit dut (.*);

  batch_sigma_outlier_stats_checker checker_i (.*);

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (calm || $urandom_range(0, 5) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 4) - 1) @(posedge clk);
    end
  end

  task automatic send_word(input logic [SAMPLE_BITS-1:0] s, input logic l);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain_stats();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_stats != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_sigmas(input logic [K_W-1:0] k);
    drain_stats();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_SIGMAS;
    cfg_pwdata <= 32'(k);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int spread);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom());
      default: return 16'($signed($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  task automatic send_batch(input int len, input int spread);
    for (int i = 0; i < len; i++)
      send_word((i % 13 == 5 && $urandom_range(0, 3) == 0) ? 16'(spread * 8)
                : pick_sample(spread), i == len - 1);
  endtask

  initial begin
    int len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_word(16'sd100, 1'b1);
    send_batch(2, 50);
    for (int i = 0; i < 4; i++) send_word(16'h8000, i == 3);
    for (int i = 0; i < 3; i++) send_word(16'h7fff, i == 2);
    send_word(16'h8000, 1'b0);
    send_word(16'h7fff, 1'b1);
    for (int i = 0; i < 8; i++) send_word(i == 7 ? 16'sd2000 : 16'sd10, i == 7);
    write_sigmas(4'd0);
    send_batch(5, 30);
    for (int i = 0; i < 3; i++) send_word(16'sd7, i == 2);
    write_sigmas(4'd15);
    send_batch(6, 200);
    write_sigmas(4'd1);
    send_batch(258, 1000);
    for (int i = 0; i < 257; i++) send_word(16'(i), 1'b0);
    send_word(16'sd9, 1'b1);
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int b = 0; b < 6; b++) send_batch(4, 300);
    join
    drain_stats();
    write_sigmas(4'd3);
    for (int phase = 0; phase < 4; phase++) begin
      if (phase > 0) write_sigmas(4'($urandom_range(1, 15)));
      for (int b = 0; b < 15; b++) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 260) : $urandom_range(1, 12);
        send_batch(len, $urandom_range(1, 20000));
      end
    end
    write_sigmas(4'd2);
    calm = 1'b1;
    for (int b = 0; b < 30; b++) send_batch($urandom_range(1, 10), $urandom_range(1, 5000));
    in_valid <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 200000 && pending_stats != 0; i++) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Covered %0d sample words and %0d batch results, including overflow,", words_sent,
             batches_seen);
    $display("zero spread, extreme samples, sigma settings 0 to 15 and output stalls.");
    if (fail_count == 0 && pending_stats == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
